[rtl/core/pps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Shared constants, command codes and status types of the parallel-port
// sample FIFO.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int FifoDepth = 16;
  localparam int PtrW      = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int LevelW    = $clog2(FifoDepth + 1);

  localparam logic [15:0] PortData   = 16'h0378;
  localparam logic [15:0] PortCtrl   = 16'h037A;
  localparam int          StrobeBit  = 3;
  localparam logic [7:0]  FullFlag   = 8'h40;
  localparam logic [7:0]  SilentByte = 8'd128;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[rtl/core/pps_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_fifo
// Byte FIFO with drop-on-full push and first-word-fall-through read data.
// ----------------------------------------------------------------------------
module pps_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pps_pkg::fifo_ctrl_t  ctrl_i,
  input  logic [7:0]           wr_data_i,
  output logic [7:0]           rd_data_o,
  output pps_pkg::fifo_stat_t  stat_o
);

  localparam logic [pps_pkg::PtrW-1:0] LastSlot = pps_pkg::PtrW'(pps_pkg::FifoDepth - 1);
  localparam logic [pps_pkg::LevelW-1:0] FullLevel = pps_pkg::LevelW'(pps_pkg::FifoDepth);

  logic [7:0]                store_q [pps_pkg::FifoDepth];
  logic [pps_pkg::PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [pps_pkg::PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [pps_pkg::LevelW-1:0] level_q, level_d;
  logic                      do_push, do_pop;

  assign stat_o.full  = (level_q == FullLevel);
  assign stat_o.empty = (level_q == '0);
  assign rd_data_o    = store_q[rd_ptr_q];

  // push on full is dropped; pop on empty does nothing
  assign do_push = ctrl_i.push && !stat_o.full;
  assign do_pop  = ctrl_i.pop && !stat_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   level_d = level_q + 1'b1;
      2'b01:   level_d = level_q - 1'b1;
      default: level_d = level_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= wr_data_i;
    end
  end

  a_not_full_and_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat_o.full && stat_o.empty))
    else $error("fifo reports full and empty");

  a_drop_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.push && !ctrl_i.pop && stat_o.full) |=> $stable(level_q) && $stable(wr_ptr_q))
    else $error("push on full fifo changed state");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= FullLevel)
    else $error("fifo level overflow");

endmodule

[rtl/core/parallel_port_sample_fifo_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallel_port_sample_fifo_top
// Parallel-port sound device: port writes/reads and sample ticks over a
// byte FIFO.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one command word per handshake: tuser holds the
//   command (write, read, tick), tdata the port address and write byte.
//   A write to the data port latches a byte; a write to the control port
//   pushes the latched byte when control bit 3 falls (dropped when full).
//   A read of an odd port gives the full flag, an even port the data latch.
//   A tick pops a byte and returns the signed sample (byte - 128) << 8;
//   on an empty FIFO it repeats the last sample with sample_fresh low.
//   Master channel returns exactly one result word per command word.
// Latency / throughput:
//   Result valid the cycle after accept; one word per cycle unless the
//   master stalls, set by the single result register on the master side.
// Reset:
//   FIFO empty, latch and control byte zero, last sample silent.
// Stall:
//   While the result register holds an untaken word, tready drops; the
//   word is taken in the same cycle the master side accepts.
// ----------------------------------------------------------------------------
module parallel_port_sample_fifo_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] port_address, [23:16] write_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] read_data, [23:8] sample_value
  output logic        m_axis_tuser    // [0] sample_fresh
);

  logic                s_accept;
  pps_pkg::cmd_e       cmd;
  logic [15:0]         port_addr;
  logic [7:0]          wr_byte;
  pps_pkg::fifo_ctrl_t fifo_ctrl;
  pps_pkg::fifo_stat_t fifo_stat;
  logic [7:0]          fifo_rd_data;

  logic [7:0]  latch_q, latch_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [7:0]  last_q, last_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  rd_data_q, rd_data_d;
  logic [15:0] sample_q, sample_d;
  logic        fresh_q, fresh_d;

  assign cmd       = pps_pkg::cmd_e'(s_axis_tuser);
  assign port_addr = s_axis_tdata[15:0];
  assign wr_byte   = s_axis_tdata[23:16];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  pps_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (fifo_ctrl),
    .wr_data_i (latch_q),
    .rd_data_o (fifo_rd_data),
    .stat_o    (fifo_stat)
  );

  always_comb begin
    latch_d        = latch_q;
    ctrl_d         = ctrl_q;
    last_d         = last_q;
    fifo_ctrl.push = 1'b0;
    fifo_ctrl.pop  = 1'b0;
    rd_data_d      = '0;
    sample_d       = '0;
    fresh_d        = 1'b0;
    out_valid_d    = out_valid_q && !m_axis_tready;
    if (s_accept) begin
      out_valid_d = 1'b1;
      unique case (cmd)
        pps_pkg::CMD_WRITE: begin
          if (port_addr == pps_pkg::PortData) begin
            latch_d = wr_byte;
          end else if (port_addr == pps_pkg::PortCtrl) begin
            // strobe falling edge pushes the latched byte
            fifo_ctrl.push = ctrl_q[pps_pkg::StrobeBit] && !wr_byte[pps_pkg::StrobeBit];
            ctrl_d         = wr_byte;
          end
        end
        pps_pkg::CMD_READ: begin
          if (port_addr[0]) begin
            rd_data_d = fifo_stat.full ? pps_pkg::FullFlag : 8'h00;
          end else begin
            rd_data_d = latch_q;
          end
        end
        pps_pkg::CMD_TICK: begin
          if (!fifo_stat.empty) begin
            fifo_ctrl.pop = 1'b1;
            last_d        = fifo_rd_data;
            fresh_d       = 1'b1;
          end
          sample_d = {last_d ^ 8'h80, 8'h00};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q     <= '0;
      ctrl_q      <= '0;
      last_q      <= pps_pkg::SilentByte;
      out_valid_q <= 1'b0;
    end else begin
      latch_q     <= latch_d;
      ctrl_q      <= ctrl_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      rd_data_q <= rd_data_d;
      sample_q  <= sample_d;
      fresh_q   <= fresh_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {sample_q, rd_data_q};
  assign m_axis_tuser  = fresh_q;

  a_fresh_no_read_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'h00))
    else $error("fresh sample carries read data");

  a_empty_tick_stale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && cmd == pps_pkg::CMD_TICK && fifo_stat.empty)
      |=> (m_axis_tvalid && !m_axis_tuser))
    else $error("tick on empty fifo marked fresh");

  a_write_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && cmd == pps_pkg::CMD_WRITE) |=> (m_axis_tdata == 24'h0 && !m_axis_tuser))
    else $error("port write produced nonzero result");

endmodule
